### rtl/core/asymmetric_tanh_saturator_macros.svh
// assertion macros for the asymmetric tanh saturator checker
// no dependencies; included by the checker file
`ifndef ASYMMETRIC_TANH_SATURATOR_MACROS_SVH
`define ASYMMETRIC_TANH_SATURATOR_MACROS_SVH

// same-cycle implication
`define ATSAT_ASSERT_SAME(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("atsat check failed");

// next-cycle implication
`define ATSAT_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("atsat check failed");

`endif

### rtl/core/atsat_pkg.sv
// shared constants, types and table builders for the asymmetric tanh saturator
// no dependencies; used by atsat_shaper, the top level and the checker
`timescale 1ns / 1ps

package atsat_pkg;

    localparam int SAMPLE_BITS      = 24;
    localparam int TANH_TABLE_DEPTH = 1024;
    localparam int EXP_TABLE_DEPTH  = 256;

    localparam int TANH_RANGE = 8;
    localparam int EXP_RANGE  = 16;
    localparam int Q          = 30;
    localparam int DRIVE_W    = 17;
    localparam int SIG_W      = 32;
    localparam int SHAPER_STAGES = 17;

    localparam logic [DRIVE_W-1:0] DRIVE_RESET = 17'd32768;

    localparam longint Q_ONE  = 64'sd1 <<< Q;
    localparam longint Q_HALF = 64'sd1 <<< (Q - 1);

    typedef logic signed [SIG_W-1:0] sig_t;
    typedef logic signed [31:0]      rom_word_t;
    typedef rom_word_t tanh_rom_t [0:TANH_TABLE_DEPTH];
    typedef rom_word_t exp_rom_t  [0:EXP_TABLE_DEPTH];

    typedef struct packed {
        logic [18:0] pre;
        logic [19:0] gpos;
        logic [19:0] gneg;
        logic [14:0] emph;
        logic [16:0] wet;
        logic [16:0] dry;
        logic        two_pass;
    } drive_cfg_t;

    // restoring division of non-negative values
    function automatic longint udiv(input longint num, input longint den);
        longint quo;
        longint rem;
        quo = 0;
        rem = 0;
        for (int b = 62; b >= 0; b--)
        begin
            rem = (rem <<< 1) | ((num >>> b) & 64'sd1);
            quo = quo <<< 1;
            if (rem >= den)
            begin
                rem = rem - den;
                quo = quo | 64'sd1;
            end
        end
        return quo;
    endfunction

    // exp(-f), f in [0, 1.0], taylor series in q.30
    function automatic longint exp_frac(input longint f);
        longint term;
        longint sum;
        term = Q_ONE;
        sum  = Q_ONE;
        for (int n = 1; n <= 20; n++) begin
            term = udiv((term * f + Q_HALF) >>> Q, longint'(n));
            if (n[0])
                sum = sum - term;
            else
                sum = sum + term;
        end
        return sum;
    endfunction

    // exp(-x), x >= 0, q.30
    function automatic longint exp_neg(input longint x);
        longint n;
        longint r;
        longint e1;
        n = x >>> Q;
        if (n > 40)
            return 64'sd0;
        r  = exp_frac(x & (Q_ONE - 1));
        e1 = exp_frac(Q_ONE);
        for (longint k = 0; k < n; k++)
            r = (r * e1 + Q_HALF) >>> Q;
        return r;
    endfunction

    function automatic tanh_rom_t build_tanh();
        tanh_rom_t tab;
        longint x;
        longint e;
        longint den;
        for (int i = 0; i <= TANH_TABLE_DEPTH; i++) begin
            x      = ((longint'(i) * TANH_RANGE) <<< Q) / TANH_TABLE_DEPTH;
            e      = exp_neg(2 * x);
            den    = Q_ONE + e;
            tab[i] = 32'(udiv(((Q_ONE - e) <<< Q) + den / 2, den));
        end
        return tab;
    endfunction

    function automatic exp_rom_t build_exp();
        exp_rom_t tab;
        longint x;
        for (int i = 0; i <= EXP_TABLE_DEPTH; i++) begin
            x      = ((longint'(i) * EXP_RANGE) <<< Q) / EXP_TABLE_DEPTH;
            tab[i] = 32'(exp_neg(x));
        end
        return tab;
    endfunction

endpackage

### rtl/core/asymmetric_tanh_saturator.sv
// top level of the asymmetric tanh saturator: drive register, two shaper passes,
// sample conversion and output skid; uses atsat_pkg and atsat_shaper
//
//   port group   dir   handshake            payload
//   in           in    in_valid / in_stall  in_sample (signed Q1.23)
//   out          out   out_valid / out_stall out_sample (signed Q1.23)
//   cfg          in    cfg_wen              drive_amount (Q1.16)
//
// one sample per cycle while in_stall is low; the path from input transfer to out_valid
// runs through the input register, the 17-stage shaper run twice and the output register
// reset clears the drive register to 0.5 and empties the pipe and skid stage
// a stalled output parks one result in the skid stage; the pipe then holds
// and in_stall rises until the output transfers
`timescale 1ns / 1ps

module asymmetric_tanh_saturator (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic signed [atsat_pkg::SAMPLE_BITS-1:0] in_sample,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic signed [atsat_pkg::SAMPLE_BITS-1:0] out_sample,
    input  logic                                  cfg_wen,
    input  logic [atsat_pkg::DRIVE_W-1:0]         drive_amount
);

    localparam int SB     = atsat_pkg::SAMPLE_BITS;
    localparam int FB     = SB - 1;
    localparam int Q      = atsat_pkg::Q;
    localparam int L      = atsat_pkg::SHAPER_STAGES;
    localparam int LAST   = 2 * L;
    localparam int OW     = 34;
    localparam int IN_SHL  = (FB <= Q) ? Q - FB : 0;
    localparam int IN_SHR  = (FB > Q) ? FB - Q : 0;
    localparam int OUT_SHR = (FB < Q) ? Q - FB : 0;
    localparam int OUT_SHL = (FB > Q) ? 1 : 0;
    localparam logic signed [OW-1:0] OUT_RND = (FB < Q) ? (OW'(1) <<< (Q - 1 - FB)) : '0;
    localparam logic signed [OW-1:0] OUT_MAX = (OW'(1) <<< FB) - 1;
    localparam logic signed [OW-1:0] OUT_MIN = -(OW'(1) <<< FB);

    localparam logic [16:0] DRIVE_ONE  = 17'd65536;
    localparam logic [16:0] TWO_PASS_D = 17'd45875;
    localparam logic [35:0] SHAPE_POS  = 36'd78643;
    localparam logic [35:0] SHAPE_NEG  = 36'd52429;
    localparam logic [36:0] EMPH_RECIP = 37'd419431;
    localparam logic [38:0] WET_RECIP  = 39'd838861;

    logic [atsat_pkg::DRIVE_W-1:0] drive_reg;
    atsat_pkg::drive_cfg_t         cfg_reg, cfg_next;

    logic                          vld_reg [0:LAST];
    atsat_pkg::sig_t               x0_reg;
    atsat_pkg::sig_t               ya, xa_unused_pass, yb, xb;
    logic                          adv;

    logic                          out_valid_reg;
    logic signed [SB-1:0]          out_sample_reg;
    logic                          skid_valid_reg;
    logic signed [SB-1:0]          skid_sample_reg;
    logic signed [SB-1:0]          res_sample;

    atsat_pkg::sig_t               y_sel;
    logic signed [OW-1:0]          yw;

    logic [16:0] d;
    logic [18:0] d3;
    logic [18:0] drv;

    // drive-derived factors
    always_comb
    begin
        d   = (drive_reg > DRIVE_ONE) ? DRIVE_ONE : drive_reg;
        d3  = 19'({d, 1'b0}) + 19'(d);
        drv = 19'(DRIVE_ONE) + 19'({d3, 1'b0});
        cfg_next.pre      = 19'(DRIVE_ONE) + d3;
        cfg_next.gpos     = 20'((36'(drv) * SHAPE_POS + 36'd32768) >> 16);
        cfg_next.gneg     = 20'((36'(drv) * SHAPE_NEG + 36'd32768) >> 16);
        cfg_next.emph     = 15'((37'(d3 + 19'd5) * EMPH_RECIP) >> 22);
        cfg_next.wet      = 17'((39'(d3 + 19'd131074) * WET_RECIP) >> 22);
        cfg_next.dry      = DRIVE_ONE - cfg_next.wet;
        cfg_next.two_pass = d > TWO_PASS_D;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            drive_reg <= atsat_pkg::DRIVE_RESET;
        else if (cfg_wen)
            drive_reg <= drive_amount;
    end

    always_ff @(posedge clk)
    begin
        cfg_reg <= cfg_next;
    end

    assign adv      = !skid_valid_reg;
    assign in_stall = skid_valid_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
            x0_reg <= (atsat_pkg::SIG_W'(in_sample) <<< IN_SHL) >>> IN_SHR;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= LAST; k++)
                vld_reg[k] <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg[0] <= in_valid;
            for (int k = 1; k <= LAST; k++)
                vld_reg[k] <= vld_reg[k-1];
        end
    end

    atsat_shaper u_pass_a (
        .clk   (clk),
        .en    (adv),
        .cfg   (cfg_reg),
        .x_in  (x0_reg),
        .y_out (ya),
        .x_out (xa_unused_pass)
    );

    atsat_shaper u_pass_b (
        .clk   (clk),
        .en    (adv),
        .cfg   (cfg_reg),
        .x_in  (ya),
        .y_out (yb),
        .x_out (xb)
    );

    // sample back to output format, round half up and saturate
    always_comb
    begin
        y_sel = cfg_reg.two_pass ? yb : xb;
        yw    = ((OW'(y_sel) + OUT_RND) >>> OUT_SHR) <<< OUT_SHL;
        if (yw > OUT_MAX)
            res_sample = SB'(OUT_MAX);
        else if (yw < OUT_MIN)
            res_sample = SB'(OUT_MIN);
        else
            res_sample = SB'(yw);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            if (!out_valid_reg || !out_stall)
                out_valid_reg <= vld_reg[LAST];
            else if (vld_reg[LAST])
                skid_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            skid_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (!out_valid_reg || !out_stall)
                out_sample_reg <= res_sample;
            else
                skid_sample_reg <= res_sample;
        end
        else if (!out_stall)
        begin
            out_sample_reg <= skid_sample_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_sample = out_sample_reg;

endmodule

### rtl/core/atsat_shaper.sv
// one saturator pass: pre-gain, asymmetric tanh, emphasis, knee, dry/wet mix
// uses atsat_pkg for types, constants and the tanh and exp table builders
`timescale 1ns / 1ps

module atsat_shaper (
    input  logic                   clk,
    input  logic                   en,
    input  atsat_pkg::drive_cfg_t  cfg,
    input  atsat_pkg::sig_t        x_in,
    output atsat_pkg::sig_t        y_out,
    output atsat_pkg::sig_t        x_out
);

    localparam int Q        = atsat_pkg::Q;
    localparam int L        = atsat_pkg::SHAPER_STAGES;
    localparam int ARG_W    = 37;
    localparam int TDEPTH   = atsat_pkg::TANH_TABLE_DEPTH;
    localparam int EDEPTH   = atsat_pkg::EXP_TABLE_DEPTH;
    localparam int TANH_SH  = $clog2(TDEPTH) - $clog2(atsat_pkg::TANH_RANGE);
    localparam int EXP_SH   = $clog2(EDEPTH) - $clog2(atsat_pkg::EXP_RANGE);
    localparam int TANH_FSH = Q - TANH_SH;
    localparam int EXP_FSH  = Q - EXP_SH;
    localparam int TIW      = $clog2(TDEPTH) + 1;
    localparam int EIW      = $clog2(EDEPTH) + 1;

    localparam atsat_pkg::sig_t  ONE_S  = 32'sd1073741824;
    localparam atsat_pkg::sig_t  KNEE   = 32'sd1020054733;
    localparam atsat_pkg::sig_t  SPAN   = 32'sd53687091;
    localparam logic [32:0]      THRESH = 33'd107374182;
    localparam logic signed [63:0] HALF_W = 64'sd536870912;

    localparam atsat_pkg::tanh_rom_t TANH_ROM_A = atsat_pkg::build_tanh();
    localparam atsat_pkg::tanh_rom_t TANH_ROM_B = atsat_pkg::build_tanh();
    localparam atsat_pkg::exp_rom_t  EXP_ROM    = atsat_pkg::build_exp();

    typedef struct packed {
        logic [TIW-1:0] lo;
        logic [TIW-1:0] hi;
        logic [Q-1:0]   frac;
    } tanh_addr_t;

    typedef struct packed {
        logic [EIW-1:0] lo;
        logic [EIW-1:0] hi;
        logic [Q-1:0]   frac;
    } exp_addr_t;

    function automatic tanh_addr_t tanh_addr(input logic [ARG_W-1:0] arg);
        tanh_addr_t       r;
        logic [ARG_W-1:0] ip;
        ip = arg >> TANH_FSH;
        if (ip >= ARG_W'(TDEPTH)) begin
            r.lo   = TIW'(TDEPTH);
            r.hi   = TIW'(TDEPTH);
            r.frac = '0;
        end
        else begin
            r.lo   = ip[TIW-1:0];
            r.hi   = ip[TIW-1:0] + 1'b1;
            r.frac = Q'(arg[TANH_FSH-1:0]) << TANH_SH;
        end
        return r;
    endfunction

    function automatic exp_addr_t exp_addr(input logic [ARG_W-1:0] arg);
        exp_addr_t        r;
        logic [ARG_W-1:0] ip;
        ip = arg >> EXP_FSH;
        if (ip >= ARG_W'(EDEPTH)) begin
            r.lo   = EIW'(EDEPTH);
            r.hi   = EIW'(EDEPTH);
            r.frac = '0;
        end
        else begin
            r.lo   = ip[EIW-1:0];
            r.hi   = ip[EIW-1:0] + 1'b1;
            r.frac = Q'(arg[EXP_FSH-1:0]) << EXP_SH;
        end
        return r;
    endfunction

    // stage registers
    logic signed [51:0]  p1_reg;
    logic [32:0]         a2_reg;
    logic [52:0]         p2_reg;
    logic [ARG_W-1:0]    targ3_reg;
    logic [ARG_W-1:0]    earg3_reg;
    atsat_pkg::sig_t     tlo4_reg, thi4_reg, elo4_reg, ehi4_reg;
    logic [Q-1:0]        tfrac4_reg, efrac4_reg;
    atsat_pkg::sig_t     tlo5_reg, elo5_reg;
    logic signed [63:0]  tprod5_reg, eprod5_reg;
    atsat_pkg::sig_t     s6_reg, e6_reg;
    atsat_pkg::sig_t     s7_reg;
    logic signed [63:0]  tp7_reg;
    atsat_pkg::sig_t     s8_reg;
    logic signed [47:0]  tt8_reg;
    logic [ARG_W-1:0]    karg10_reg;
    atsat_pkg::sig_t     klo11_reg, khi11_reg;
    logic [Q-1:0]        kfrac11_reg;
    atsat_pkg::sig_t     klo12_reg;
    logic signed [63:0]  kprod12_reg;
    atsat_pkg::sig_t     th13_reg;
    logic signed [63:0]  sp14_reg;
    atsat_pkg::sig_t     s15_reg;
    logic signed [49:0]  m1_16_reg, m2_16_reg;
    atsat_pkg::sig_t     y17_reg;

    // carried along the pipe
    atsat_pkg::sig_t     xd_reg    [1:L];
    logic                pos_d_reg [2:14];
    logic                efl_d_reg [3:8];
    atsat_pkg::sig_t     s_d_reg   [9:14];
    logic                kc_d_reg  [10:14];

    // next values
    logic signed [51:0]  p1_next;
    logic signed [35:0]  shaped2;
    logic                pos2;
    logic [32:0]         a2_next;
    logic [19:0]         g2;
    logic [52:0]         p2_next;
    logic [ARG_W-1:0]    targ3_next, earg3_next;
    logic                efl3_next;
    tanh_addr_t          ta4;
    exp_addr_t           ea4;
    logic signed [63:0]  tprod5_next, eprod5_next;
    atsat_pkg::sig_t     s6_next, e6_next;
    logic signed [63:0]  tp7_next;
    atsat_pkg::sig_t     t8;
    logic signed [47:0]  tt8_next;
    atsat_pkg::sig_t     s9_next;
    logic signed [ARG_W-1:0] kd10;
    logic signed [ARG_W-1:0] karg10_next;
    logic                kc10_next;
    tanh_addr_t          ka11;
    logic signed [63:0]  kprod12_next;
    atsat_pkg::sig_t     th13_next;
    logic signed [63:0]  sp14_next;
    atsat_pkg::sig_t     s15_mag, s15_next;
    logic signed [49:0]  m1_16_next, m2_16_next;
    logic signed [50:0]  sum17;
    logic signed [34:0]  y35;
    atsat_pkg::sig_t     y17_next;

    always_comb
    begin
        p1_next = x_in * $signed({1'b0, cfg.pre});

        shaped2 = 36'(p1_reg >>> 16);
        pos2    = shaped2 > 36'sd0;
        a2_next = pos2 ? 33'(shaped2) : 33'(-shaped2);
        g2      = pos2 ? cfg.gpos : cfg.gneg;
        p2_next = 53'(a2_next) * 53'(g2);

        targ3_next = ARG_W'((p2_reg + 53'd32768) >> 16);
        earg3_next = ARG_W'({a2_reg, 2'b00}) + ARG_W'(a2_reg);
        efl3_next  = pos_d_reg[2] && (a2_reg > THRESH);

        ta4 = tanh_addr(targ3_reg);
        ea4 = exp_addr(earg3_reg);

        tprod5_next = (33'(thi4_reg) - 33'(tlo4_reg)) * $signed({1'b0, tfrac4_reg});
        eprod5_next = (33'(ehi4_reg) - 33'(elo4_reg)) * $signed({1'b0, efrac4_reg});

        s6_next = tlo5_reg + 32'((tprod5_reg + HALF_W) >>> Q);
        e6_next = elo5_reg + 32'((eprod5_reg + HALF_W) >>> Q);

        tp7_next = 64'(s6_reg) * 64'(ONE_S - e6_reg);

        t8       = 32'((tp7_reg + HALF_W) >>> Q);
        tt8_next = t8 * $signed({1'b0, cfg.emph});

        s9_next = efl_d_reg[8] ? s8_reg + 32'((tt8_reg + 48'sd32768) >>> 16) : s8_reg;

        kd10        = ARG_W'(s_d_reg[9]) - ARG_W'(KNEE);
        karg10_next = (kd10 <<< 3) + (kd10 <<< 1);
        kc10_next   = s_d_reg[9] > KNEE;

        ka11 = tanh_addr(karg10_reg);

        kprod12_next = (33'(khi11_reg) - 33'(klo11_reg)) * $signed({1'b0, kfrac11_reg});

        th13_next = klo12_reg + 32'((kprod12_reg + HALF_W) >>> Q);

        sp14_next = 64'(th13_reg) * 64'(SPAN);

        s15_mag  = kc_d_reg[14] ? KNEE + 32'((sp14_reg + HALF_W) >>> Q) : s_d_reg[14];
        s15_next = pos_d_reg[14] ? s15_mag : -s15_mag;

        m1_16_next = xd_reg[15] * $signed({1'b0, cfg.dry});
        m2_16_next = s15_reg * $signed({1'b0, cfg.wet});

        sum17 = 51'(m1_16_reg) + 51'(m2_16_reg) + 51'sd32768;
        y35   = 35'(sum17 >>> 16);
        if (y35 > 35'(ONE_S))
            y17_next = ONE_S;
        else if (y35 < -35'(ONE_S))
            y17_next = -ONE_S;
        else
            y17_next = 32'(y35);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_reg       <= p1_next;
            a2_reg       <= a2_next;
            p2_reg       <= p2_next;
            targ3_reg    <= targ3_next;
            earg3_reg    <= earg3_next;
            tlo4_reg     <= TANH_ROM_A[ta4.lo];
            thi4_reg     <= TANH_ROM_A[ta4.hi];
            tfrac4_reg   <= ta4.frac;
            elo4_reg     <= EXP_ROM[ea4.lo];
            ehi4_reg     <= EXP_ROM[ea4.hi];
            efrac4_reg   <= ea4.frac;
            tlo5_reg     <= tlo4_reg;
            elo5_reg     <= elo4_reg;
            tprod5_reg   <= tprod5_next;
            eprod5_reg   <= eprod5_next;
            s6_reg       <= s6_next;
            e6_reg       <= e6_next;
            s7_reg       <= s6_reg;
            tp7_reg      <= tp7_next;
            s8_reg       <= s7_reg;
            tt8_reg      <= tt8_next;
            karg10_reg   <= karg10_next;
            klo11_reg    <= TANH_ROM_B[ka11.lo];
            khi11_reg    <= TANH_ROM_B[ka11.hi];
            kfrac11_reg  <= ka11.frac;
            klo12_reg    <= klo11_reg;
            kprod12_reg  <= kprod12_next;
            th13_reg     <= th13_next;
            sp14_reg     <= sp14_next;
            s15_reg      <= s15_next;
            m1_16_reg    <= m1_16_next;
            m2_16_reg    <= m2_16_next;
            y17_reg      <= y17_next;

            xd_reg[1] <= x_in;
            for (int k = 2; k <= L; k++)
                xd_reg[k] <= xd_reg[k-1];
            pos_d_reg[2] <= pos2;
            for (int k = 3; k <= 14; k++)
                pos_d_reg[k] <= pos_d_reg[k-1];
            efl_d_reg[3] <= efl3_next;
            for (int k = 4; k <= 8; k++)
                efl_d_reg[k] <= efl_d_reg[k-1];
            s_d_reg[9] <= s9_next;
            for (int k = 10; k <= 14; k++)
                s_d_reg[k] <= s_d_reg[k-1];
            kc_d_reg[10] <= kc10_next;
            for (int k = 11; k <= 14; k++)
                kc_d_reg[k] <= kc_d_reg[k-1];
        end
    end

    assign y_out = y17_reg;
    assign x_out = xd_reg[L];

endmodule

### rtl/core/atsat_checker.sv
// port-level checks for the asymmetric tanh saturator, bound to the top level
// uses atsat_pkg and asymmetric_tanh_saturator_macros.svh
`timescale 1ns / 1ps
`include "asymmetric_tanh_saturator_macros.svh"

module atsat_checker (
    input logic                                   clk,
    input logic                                   rst_n,
    input logic                                   in_stall,
    input logic                                   out_valid,
    input logic                                   out_stall,
    input logic signed [atsat_pkg::SAMPLE_BITS-1:0] out_sample
);

    // input backpressure only comes from a parked result
    `ATSAT_ASSERT_SAME(a_stall_has_out, clk, rst_n, in_stall, out_valid)
    `ATSAT_ASSERT_SAME(a_stall_after_out_stall, clk, rst_n, in_stall, $past(out_valid && out_stall))
    `ATSAT_ASSERT_NEXT(a_empty_out_no_stall, clk, rst_n, !out_valid, !in_stall)
    `ATSAT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_sample))

endmodule

bind asymmetric_tanh_saturator atsat_checker u_atsat_checker (.*);
